### rtl/cpir_pkg.sv
package cpir_pkg;

  // Field widths of the item and result ports
  localparam int PLANE_W = 8;
  localparam int ROW_W   = 6;
  localparam int PAIR_W  = 6;
  localparam int DATA_W  = 32;

  // Configuration register widths and port shape
  localparam int IN_PLANES_W  = 5;
  localparam int OUT_PLANES_W = 9;
  localparam int COUNT_W      = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_PLANES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_PLANES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_PAIRS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd4;

  // Configuration reset values
  localparam logic [IN_PLANES_W-1:0]  IN_PLANES_RST  = 5'd2;
  localparam logic [OUT_PLANES_W-1:0] OUT_PLANES_RST = 9'd2;
  localparam logic [COUNT_W-1:0]      ROW_COUNT_RST  = 7'd64;
  localparam logic [COUNT_W-1:0]      IN_PAIRS_RST   = 7'd64;
  localparam logic [COUNT_W-1:0]      STEP_RST       = 7'd1;

  // Source pair (pair * step) and plane position (plane * (in_planes - 1))
  localparam int SRC_W = PAIR_W + COUNT_W;
  localparam int POS_W = PLANE_W + IN_PLANES_W;

  // Long division of pos * 2^17 by out_planes - 1
  localparam int FRAC_W          = 17;
  localparam int QUO_W           = POS_W + FRAC_W;
  localparam int REM_W           = OUT_PLANES_W;
  localparam int STEPS_PER_STAGE = 8;
  localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Interpolation weight, 1.0 = 2^16
  localparam int ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;

  // Item context carried alongside the divider
  typedef struct packed {
    logic              rd;
    logic              err;
    logic              ld_ok;
    logic [PLANE_W-1:0] pl;
    logic [ROW_W-1:0]  row;
    logic [SRC_W-1:0]  src;
    logic [DATA_W-1:0] ld_re;
    logic [DATA_W-1:0] ld_im;
  } tag_t;

  // Context of a read while the sample banks answer
  typedef struct packed {
    logic               err;
    logic               swap;
    logic [ALPHA_W-1:0] alpha;
  } mem_tag_t;

endpackage

### rtl/cpir_ram.sv
module cpir_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/complex_plane_interp_resampler_core.sv
// Complex plane resampler: holds a cube of complex Q16.16 samples and returns
// values interpolated linearly between two neighbouring input planes.
// Input channel: an item is taken at a rising edge with start high and busy
// low; busy stays low, so an item may follow in every cycle. func_i = 0 loads
// load_re_i/load_im_i at (plane_i, row_i, pair_i) and gives no result;
// func_i = 1 asks for output plane plane_i, row row_i, output pair pair_i.
// Result channel: out_valid_o is high for exactly one cycle per read, with
// out_re_o, out_im_o and status_o; the receiver cannot hold it off.
// An item passes stage 0, the four divider stages, the bank read and the
// difference, product and result registers. Throughput: one item per cycle. The
// sample store is split into an even-plane and an odd-plane bank, each with
// one read port, so both planes of a read come out in the same cycle; a
// four-stage long divider (eight quotient bits a stage, six in the last)
// finds the plane index and weight ahead of the bank access.
// Reset clears the pipeline and the configuration registers to their reset
// values; the sample store keeps whatever it held and needs no clearing pass.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
// the user makes them only while no read is in flight; the block does not enforce it.
module complex_plane_interp_resampler_core #(
  parameter int MAX_PLANES = 16,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_PAIRS  = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               func_i,
  input  logic [cpir_pkg::PLANE_W-1:0]       plane_i,
  input  logic [cpir_pkg::ROW_W-1:0]         row_i,
  input  logic [cpir_pkg::PAIR_W-1:0]        pair_i,
  input  logic signed [cpir_pkg::DATA_W-1:0] load_re_i,
  input  logic signed [cpir_pkg::DATA_W-1:0] load_im_i,
  input  logic                               cfg_we_i,
  input  logic [cpir_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cpir_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                               out_valid_o,
  output logic signed [cpir_pkg::DATA_W-1:0] out_re_o,
  output logic signed [cpir_pkg::DATA_W-1:0] out_im_o,
  output logic                               status_o
);

  import cpir_pkg::*;

  localparam int BANK_PLANES = (MAX_PLANES + 1) / 2;
  localparam int BANK_DEPTH  = BANK_PLANES * MAX_ROWS * MAX_PAIRS;
  localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int IDX_W       = POS_W - 1;
  localparam int RES_LAT     = DIV_STAGES + 5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [IN_PLANES_W-1:0]  in_planes_q;
  logic [OUT_PLANES_W-1:0] out_planes_q;
  logic [COUNT_W-1:0]      row_count_q;
  logic [COUNT_W-1:0]      in_pairs_q;
  logic [COUNT_W-1:0]      step_q;

  // Write the addressed register, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_planes_q  <= IN_PLANES_RST;
      out_planes_q <= OUT_PLANES_RST;
      row_count_q  <= ROW_COUNT_RST;
      in_pairs_q   <= IN_PAIRS_RST;
      step_q       <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IN_PLANES:  in_planes_q  <= cfg_data_i[IN_PLANES_W-1:0];
        CFG_OUT_PLANES: out_planes_q <= cfg_data_i[OUT_PLANES_W-1:0];
        CFG_ROW_COUNT:  row_count_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_IN_PAIRS:   in_pairs_q   <= cfg_data_i[COUNT_W-1:0];
        CFG_STEP:       step_q       <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline takes an item in every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Accept: range checks, source pair and plane position
  // ---------------------------------------------------------------------------
  logic                 acc;
  logic                 cfg_ok;
  logic                 idx_ok;
  logic                 ld_ok;
  logic [SRC_W-1:0]     src;
  logic [POS_W-1:0]     pos;
  logic [IN_PLANES_W-1:0] nm1;
  logic [REM_W-1:0]     div_den;
  tag_t                 tag_in;

  assign acc     = start && !busy;
  assign nm1     = in_planes_q - IN_PLANES_W'(1);
  assign div_den = out_planes_q - OUT_PLANES_W'(1);

  always_comb begin
    cfg_ok = (out_planes_q >= OUT_PLANES_W'(2)) && (in_planes_q >= IN_PLANES_W'(2)) &&
             (int'(in_planes_q) <= MAX_PLANES) &&
             (row_count_q != '0) && (int'(row_count_q) <= MAX_ROWS) &&
             (in_pairs_q != '0) && (int'(in_pairs_q) <= MAX_PAIRS) && (step_q != '0);
    src    = {{COUNT_W{1'b0}}, pair_i} * {{PAIR_W{1'b0}}, step_q};
    idx_ok = ({1'b0, plane_i} < out_planes_q) && ({1'b0, row_i} < row_count_q) &&
             (src < {{PAIR_W{1'b0}}, in_pairs_q});
    ld_ok  = (int'(plane_i) < MAX_PLANES) && (int'(row_i) < MAX_ROWS) &&
             (int'(pair_i) < MAX_PAIRS);
    pos    = {{IN_PLANES_W{1'b0}}, plane_i} * {{PLANE_W{1'b0}}, nm1};

    tag_in.rd    = func_i;
    tag_in.err   = !(cfg_ok && idx_ok);
    tag_in.ld_ok = ld_ok;
    tag_in.pl    = plane_i;
    tag_in.row   = row_i;
    tag_in.src   = func_i ? src : {{COUNT_W{1'b0}}, pair_i};
    tag_in.ld_re = load_re_i;
    tag_in.ld_im = load_im_i;
  end

  // ---------------------------------------------------------------------------
  // Divider pipeline: stage 0 holds the accepted item
  // ---------------------------------------------------------------------------
  logic             pipe_vld_q [DIV_STAGES+1];
  tag_t             tag_q      [DIV_STAGES+1];
  logic [REM_W-1:0] div_rem_q  [DIV_STAGES+1];
  logic [QUO_W-1:0] div_quo_q  [DIV_STAGES+1];
  logic [QUO_W-1:0] div_dvd_q  [DIV_STAGES+1];

  // Capture the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q[0] <= 1'b0;
    end else begin
      pipe_vld_q[0] <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0]     <= tag_in;
    div_rem_q[0] <= '0;
    div_quo_q[0] <= '0;
    div_dvd_q[0] <= {pos, {FRAC_W{1'b0}}};
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int LO = s * STEPS_PER_STAGE;
    localparam int HI = (LO + STEPS_PER_STAGE > QUO_W) ? QUO_W : LO + STEPS_PER_STAGE;

    logic [REM_W-1:0] rem_c;
    logic [QUO_W-1:0] quo_c;
    logic [REM_W:0]   trial;

    // Restoring division, one quotient bit per step, MSB first
    always_comb begin
      rem_c = div_rem_q[s];
      quo_c = div_quo_q[s];
      trial = '0;
      for (int j = LO; j < HI; j++) begin
        trial = {rem_c, div_dvd_q[s][QUO_W-1-j]};
        if (trial >= {1'b0, div_den}) begin
          trial              = trial - {1'b0, div_den};
          quo_c[QUO_W-1-j]   = 1'b1;
        end
        rem_c = trial[REM_W-1:0];
      end
    end

    // Advance to the next stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_vld_q[s+1] <= 1'b0;
      end else begin
        pipe_vld_q[s+1] <= pipe_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[s+1]     <= tag_q[s];
      div_rem_q[s+1] <= rem_c;
      div_quo_q[s+1] <= quo_c;
      div_dvd_q[s+1] <= div_dvd_q[s];
    end
  end

  // ---------------------------------------------------------------------------
  // Bank access: loads and reads reach the banks in item order from this one
  // stage, so a read always sees every earlier load and no forwarding is needed
  // ---------------------------------------------------------------------------
  tag_t               t_m;
  logic               v_m;
  logic [QUO_W-1:0]   q_m;
  logic [IDX_W:0]     i_raw;
  logic [IDX_W:0]     i_c;
  logic [ALPHA_W-1:0] alpha;
  logic               swap;
  logic [IDX_W-1:0]   base;
  logic [IDX_W-1:0]   even_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic               rd_en;
  logic               wr_en;
  logic               even_we;
  logic               odd_we;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      even_raddr;
  logic [AW-1:0]      odd_raddr;
  logic [2*DATA_W-1:0] wr_data;
  logic [2*DATA_W-1:0] even_rdata;
  logic [2*DATA_W-1:0] odd_rdata;

  assign t_m = tag_q[DIV_STAGES];
  assign v_m = pipe_vld_q[DIV_STAGES];
  assign q_m = div_quo_q[DIV_STAGES];

  always_comb begin
    // Integer plane, rounded weight, final-plane clamp
    i_raw = q_m[QUO_W-1:FRAC_W];
    alpha = ALPHA_W'(({1'b0, q_m[FRAC_W-1:0]} + (FRAC_W+1)'(1)) >> 1);
    i_c   = i_raw;
    if (i_raw >= (IDX_W+1)'(nm1)) begin
      i_c   = (IDX_W+1)'(nm1) - (IDX_W+1)'(1);
      alpha = ALPHA_ONE;
    end
    swap     = i_c[0];
    base     = i_c[IDX_W:1];
    even_idx = swap ? base + IDX_W'(1) : base;

    rd_en   = v_m && t_m.rd && !t_m.err;
    wr_en   = v_m && !t_m.rd && t_m.ld_ok;
    even_we = wr_en && !t_m.pl[0];
    odd_we  = wr_en && t_m.pl[0];
    wr_idx  = IDX_W'(t_m.pl[PLANE_W-1:1]);
    wr_data = {t_m.ld_im, t_m.ld_re};

    wr_addr    = AW'((int'(wr_idx) * MAX_ROWS + int'(t_m.row)) * MAX_PAIRS +
                     int'(t_m.src));
    even_raddr = AW'((int'(even_idx) * MAX_ROWS + int'(t_m.row)) * MAX_PAIRS +
                     int'(t_m.src));
    odd_raddr  = AW'((int'(base) * MAX_ROWS + int'(t_m.row)) * MAX_PAIRS +
                     int'(t_m.src));
  end

  cpir_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (BANK_DEPTH)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (even_raddr),
    .rdata_o (even_rdata)
  );

  cpir_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (BANK_DEPTH)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (odd_raddr),
    .rdata_o (odd_rdata)
  );

  // Hold read context while the banks answer
  logic     m_vld_q;
  mem_tag_t m_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= v_m && t_m.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    m_tag_q.err   <= t_m.err;
    m_tag_q.swap  <= swap;
    m_tag_q.alpha <= alpha;
  end

  // ---------------------------------------------------------------------------
  // Interpolate: a + round((b - a) * alpha / 2^16)
  // ---------------------------------------------------------------------------
  logic [2*DATA_W-1:0]        ent_a;
  logic [2*DATA_W-1:0]        ent_b;
  logic                       x_vld_q;
  logic                       x_err_q;
  logic [ALPHA_W-1:0]         x_alpha_q;
  logic signed [DATA_W-1:0]   x_a_re_q;
  logic signed [DATA_W-1:0]   x_a_im_q;
  logic signed [DIFF_W-1:0]   x_d_re_q;
  logic signed [DIFF_W-1:0]   x_d_im_q;

  // Plane i sits in the odd bank when i is odd
  assign ent_a = m_tag_q.swap ? odd_rdata : even_rdata;
  assign ent_b = m_tag_q.swap ? even_rdata : odd_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= 1'b0;
    end else begin
      x_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_err_q   <= m_tag_q.err;
    x_alpha_q <= m_tag_q.alpha;
    x_a_re_q  <= ent_a[DATA_W-1:0];
    x_a_im_q  <= ent_a[2*DATA_W-1:DATA_W];
    x_d_re_q  <= $signed({ent_b[DATA_W-1], ent_b[DATA_W-1:0]}) -
                 $signed({ent_a[DATA_W-1], ent_a[DATA_W-1:0]});
    x_d_im_q  <= $signed({ent_b[2*DATA_W-1], ent_b[2*DATA_W-1:DATA_W]}) -
                 $signed({ent_a[2*DATA_W-1], ent_a[2*DATA_W-1:DATA_W]});
  end

  // Weight the difference
  logic                     p_vld_q;
  logic                     p_err_q;
  logic signed [DATA_W-1:0] p_a_re_q;
  logic signed [DATA_W-1:0] p_a_im_q;
  logic signed [PROD_W-1:0] p_prod_re_q;
  logic signed [PROD_W-1:0] p_prod_im_q;
  logic signed [ALPHA_W:0]  x_alpha_s;

  assign x_alpha_s = $signed({1'b0, x_alpha_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= x_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_err_q     <= x_err_q;
    p_a_re_q    <= x_a_re_q;
    p_a_im_q    <= x_a_im_q;
    p_prod_re_q <= x_d_re_q * x_alpha_s;
    p_prod_im_q <= x_d_im_q * x_alpha_s;
  end

  // Round half up, add the base sample
  localparam int SH_W = PROD_W - 16;

  logic signed [PROD_W-1:0] rnd_re;
  logic signed [PROD_W-1:0] rnd_im;
  logic signed [SH_W-1:0]   sum_re;
  logic signed [SH_W-1:0]   sum_im;

  always_comb begin
    rnd_re = p_prod_re_q + PROD_W'(32768);
    rnd_im = p_prod_im_q + PROD_W'(32768);
    sum_re = $signed(rnd_re[PROD_W-1:16]) +
             $signed({{(SH_W-DATA_W){p_a_re_q[DATA_W-1]}}, p_a_re_q});
    sum_im = $signed(rnd_im[PROD_W-1:16]) +
             $signed({{(SH_W-DATA_W){p_a_im_q[DATA_W-1]}}, p_a_im_q});
  end

  // ---------------------------------------------------------------------------
  // Result register: zero data on error
  // ---------------------------------------------------------------------------
  logic                     out_valid_q;
  logic                     status_q;
  logic signed [DATA_W-1:0] out_re_q;
  logic signed [DATA_W-1:0] out_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= p_err_q;
    out_re_q <= p_err_q ? '0 : sum_re[DATA_W-1:0];
    out_im_q <= p_err_q ? '0 : sum_im[DATA_W-1:0];
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && func_i, RES_LAT))
    else $error("result strobe without a read item at the expected latency");

  a_even_bank_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(even_we && rd_en))
    else $error("even bank written and read in the same cycle");

  a_odd_bank_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(odd_we && rd_en))
    else $error("odd bank written and read in the same cycle");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vld_q && m_tag_q.alpha[ALPHA_W-1]) |-> (m_tag_q.alpha[ALPHA_W-2:0] == '0))
    else $error("interpolation weight above one");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (out_re_o == '0 && out_im_o == '0))
    else $error("error result carries non-zero data");

endmodule
